/* src/btpl_pkg.sv */
// Shared constants, payload types and node-memory types of the prefix lookup engine.
package btpl_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int ADDR_BITS  = 32;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int USED_W = $clog2(NODE_COUNT + 1);
  localparam int LVL_W  = $clog2(ADDR_BITS + 1);
  localparam int BIT_W  = $clog2(ADDR_BITS);
  localparam int PORT_W = 8;
  localparam int LEN_W  = 6;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [PORT_W-1:0] DEFAULT_PORT_RST = PORT_W'(255);

  // Word index of the default port register.
  localparam logic [APB_ADDR_W-3:0] REG_DEFAULT_PORT = '0;

  typedef struct packed {
    logic                 req_type;
    logic [ADDR_BITS-1:0] addr;
    logic [LEN_W-1:0]     prefix_len;
    logic [PORT_W-1:0]    port_in;
  } req_t;

  typedef struct packed {
    logic [PORT_W-1:0] port_out;
    logic              matched;
    logic              table_full;
  } rsp_t;

  typedef struct packed {
    logic [NODE_W-1:0] left_link;
    logic [NODE_W-1:0] right_link;
    logic              prefix_mark;
    logic [PORT_W-1:0] node_port;
  } node_ent_t;

  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    node_ent_t         wr_data;
  } mem_req_t;

endpackage

/* src/btpl_node_ram.sv */
// Single-port-write, registered-read node memory holding the trie nodes.
module btpl_node_ram (
  input  logic                 clk,
  input  btpl_pkg::mem_req_t   mem_req,
  output btpl_pkg::node_ent_t  rd_data
);

  btpl_pkg::node_ent_t mem [btpl_pkg::NODE_COUNT];
  btpl_pkg::node_ent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/btpl_cfg.sv */
// APB register block holding the default port.
module btpl_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [btpl_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [btpl_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [btpl_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [btpl_pkg::PORT_W-1:0]         default_port
);

  logic [btpl_pkg::PORT_W-1:0] default_port_r;
  logic [btpl_pkg::PORT_W-1:0] default_port_nxt;
  logic                        hit_reg;

  assign hit_reg = (paddr[btpl_pkg::APB_ADDR_W-1:2] == btpl_pkg::REG_DEFAULT_PORT);

  always_comb begin
    default_port_nxt = default_port_r;
    if (psel && penable && pwrite && hit_reg) begin
      default_port_nxt = pwdata[btpl_pkg::PORT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_port_r <= btpl_pkg::DEFAULT_PORT_RST;
    end else begin
      default_port_r <= default_port_nxt;
    end
  end

  assign prdata       = hit_reg ? btpl_pkg::APB_DATA_W'(default_port_r) : '0;
  assign pready       = 1'b1;
  assign default_port = default_port_r;

endmodule

/* src/btpl_walker.sv */
// Trie walk sequencer: descends one level per cycle, allocates nodes and forms results.
module btpl_walker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  btpl_pkg::req_t                in_item,
  input  logic [btpl_pkg::PORT_W-1:0]   default_port,
  output logic                          busy,
  output btpl_pkg::mem_req_t            mem_req,
  input  btpl_pkg::node_ent_t           mem_rd_data,
  output logic                          out_valid,
  output btpl_pkg::rsp_t                out_item
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_GROW = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            lookup_r, lookup_nxt;
  logic [btpl_pkg::ADDR_BITS-1:0]  addr_r, addr_nxt;
  logic [btpl_pkg::LVL_W-1:0]      len_r, len_nxt;
  logic [btpl_pkg::PORT_W-1:0]     port_r, port_nxt;
  logic [btpl_pkg::NODE_W-1:0]     node_r, node_nxt;
  logic [btpl_pkg::LVL_W-1:0]      lvl_r, lvl_nxt;
  logic                            hit_r, hit_nxt;
  logic [btpl_pkg::PORT_W-1:0]     best_r, best_nxt;
  logic [btpl_pkg::USED_W-1:0]     used_r, used_nxt;
  btpl_pkg::node_ent_t             root_r, root_nxt;
  logic                            out_valid_r, out_valid_nxt;
  btpl_pkg::rsp_t                  out_item_r, out_item_nxt;

  btpl_pkg::node_ent_t             ent;
  btpl_pkg::node_ent_t             upd;
  btpl_pkg::node_ent_t             grow_ent;
  logic [btpl_pkg::BIT_W-1:0]      bit_sel;
  logic                            dir;
  logic [btpl_pkg::NODE_W-1:0]     child;
  logic [btpl_pkg::LVL_W-1:0]      need;
  logic [btpl_pkg::USED_W-1:0]     avail;
  logic                            full;
  logic                            hit_now;
  logic [btpl_pkg::PORT_W-1:0]     best_now;
  logic [btpl_pkg::NODE_W-1:0]     fresh;
  logic [btpl_pkg::LVL_W-1:0]      len_sat;

  always_comb begin
    // The root lives in flip-flops; every other node comes from the memory read.
    ent      = (node_r == '0) ? root_r : mem_rd_data;
    bit_sel  = btpl_pkg::BIT_W'(btpl_pkg::ADDR_BITS - 1) - lvl_r[btpl_pkg::BIT_W-1:0];
    dir      = addr_r[bit_sel];
    child    = dir ? ent.right_link : ent.left_link;
    need     = len_r - lvl_r;
    avail    = btpl_pkg::USED_W'(btpl_pkg::NODE_COUNT) - used_r;
    full     = (btpl_pkg::USED_W'(need) > avail);
    hit_now  = hit_r | ent.prefix_mark;
    best_now = ent.prefix_mark ? ent.node_port : best_r;
    fresh    = used_r[btpl_pkg::NODE_W-1:0];
    len_sat  = (in_item.prefix_len > btpl_pkg::LEN_W'(btpl_pkg::ADDR_BITS)) ?
               btpl_pkg::LVL_W'(btpl_pkg::ADDR_BITS) :
               btpl_pkg::LVL_W'(in_item.prefix_len);

    state_nxt     = state_r;
    lookup_nxt    = lookup_r;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    port_nxt      = port_r;
    node_nxt      = node_r;
    lvl_nxt       = lvl_r;
    hit_nxt       = hit_r;
    best_nxt      = best_r;
    used_nxt      = used_r;
    root_nxt      = root_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_req       = '0;
    upd           = ent;
    grow_ent      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          lookup_nxt = (in_item.req_type == btpl_pkg::REQ_LOOKUP);
          addr_nxt   = in_item.addr;
          len_nxt    = len_sat;
          port_nxt   = in_item.port_in;
          node_nxt   = '0;
          lvl_nxt    = '0;
          hit_nxt    = 1'b0;
          best_nxt   = '0;
          state_nxt  = ST_WALK;
        end
      end

      ST_WALK: begin
        if (lookup_r) begin
          hit_nxt  = hit_now;
          best_nxt = best_now;
          if (lvl_r == btpl_pkg::LVL_W'(btpl_pkg::ADDR_BITS) || child == '0) begin
            out_valid_nxt           = 1'b1;
            out_item_nxt.port_out   = hit_now ? best_now : default_port;
            out_item_nxt.matched    = hit_now;
            out_item_nxt.table_full = 1'b0;
            state_nxt               = ST_IDLE;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = child;
            node_nxt        = child;
            lvl_nxt         = lvl_r + btpl_pkg::LVL_W'(1);
          end
        end else if (lvl_r < len_r && child != '0) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = child;
          node_nxt        = child;
          lvl_nxt         = lvl_r + btpl_pkg::LVL_W'(1);
        end else begin
          out_item_nxt = '0;
          if (full) begin
            out_item_nxt.table_full = 1'b1;
            out_valid_nxt           = 1'b1;
            state_nxt               = ST_IDLE;
          end else begin
            if (need == '0) begin
              upd.prefix_mark = 1'b1;
              upd.node_port   = port_r;
              out_valid_nxt   = 1'b1;
              state_nxt       = ST_IDLE;
            end else begin
              // Hook the first fresh node under the deepest existing node.
              if (dir) begin
                upd.right_link = fresh;
              end else begin
                upd.left_link = fresh;
              end
              lvl_nxt   = lvl_r + btpl_pkg::LVL_W'(1);
              state_nxt = ST_GROW;
            end
            if (node_r == '0) begin
              root_nxt = upd;
            end else begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = node_r;
              mem_req.wr_data = upd;
            end
          end
        end
      end

      ST_GROW: begin
        // Each fresh node is written whole: linked to the next, or marked if last.
        if (lvl_r == len_r) begin
          grow_ent.prefix_mark = 1'b1;
          grow_ent.node_port   = port_r;
          out_item_nxt         = '0;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end else if (dir) begin
          grow_ent.right_link = fresh + btpl_pkg::NODE_W'(1);
        end else begin
          grow_ent.left_link = fresh + btpl_pkg::NODE_W'(1);
        end
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = fresh;
        mem_req.wr_data = grow_ent;
        used_nxt        = used_r + btpl_pkg::USED_W'(1);
        lvl_nxt         = lvl_r + btpl_pkg::LVL_W'(1);
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= btpl_pkg::USED_W'(1);
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lookup_r   <= lookup_nxt;
    addr_r     <= addr_nxt;
    len_r      <= len_nxt;
    port_r     <= port_nxt;
    node_r     <= node_nxt;
    lvl_r      <= lvl_nxt;
    hit_r      <= hit_nxt;
    best_r     <= best_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* src/binary_trie_prefix_lookup.sv */
// Top level of the binary-trie longest-prefix-match engine.
//
// The block keeps a binary trie of IPv4 prefixes, one address bit per level.
// A word is handed in on in_item and taken at a clock edge where start is
// high and busy is low. An insert word (req_type 0) stores addr/prefix_len
// with port_in; a lookup word (req_type 1) returns the port of the longest
// stored prefix that covers addr, or the default port when none does.
// Every word produces exactly one result word on out_item, shown for a
// single cycle with out_valid high. The receiver cannot stall it.
// A lookup descends one trie level at a time; its result is registered and
// shown as busy falls. An insert walks the existing nodes, updates the deepest
// one, then writes each new node in turn; its result follows likewise. The
// rate is set by the node memory: one read per trie level and one write per
// allocated node. A new word may be accepted in the cycle its predecessor's
// result is shown. Reset (rst_n low, synchronous) empties the table: the root
// sits in flip-flops and is cleared, and the node pool fill count returns to
// one, so no clearing pass over the memory is needed. The default port resets
// to 255 and is written over the APB port at byte address 0; the user must do
// so only while the block idles, as the block itself does not enforce it.
module binary_trie_prefix_lookup (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  btpl_pkg::req_t                   in_item,
  output logic                             out_valid,
  output btpl_pkg::rsp_t                   out_item,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [btpl_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [btpl_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [btpl_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  logic [btpl_pkg::PORT_W-1:0] default_port;
  btpl_pkg::mem_req_t          mem_req;
  btpl_pkg::node_ent_t         mem_rd_data;

  // Configuration registers.
  btpl_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .default_port (default_port)
  );

  // Node pool for every node except the root.
  btpl_node_ram u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (mem_rd_data)
  );

  // Sequencer that walks and extends the trie.
  btpl_walker u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_item      (in_item),
    .default_port (default_port),
    .busy         (busy),
    .mem_req      (mem_req),
    .mem_rd_data  (mem_rd_data),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

  // The root never lives in memory, so it is never written there.
  a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (mem_req.wr_addr != '0))
    else $error("node memory write aimed at the root");

  // The sequencer either reads or writes the memory in a cycle, never both.
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("node memory read and write in the same cycle");

  // A word accepted now cannot have its result in the next cycle.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result appeared one cycle after acceptance");

  // The block goes idle exactly when a result is delivered.
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("block went idle without a result");

  // A result is never both a match and a full-table failure.
  a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.matched && out_item.table_full))
    else $error("result flags matched and table_full both set");

endmodule
